/* sv/rsm_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsm_pkg: shared types and constants of the row segment mapper
// Field widths, command and status codes, the controller state type and the
// lookup beat that travels along the chain of boundary cells.
// ----------------------------------------------------------------------------
package rsm_pkg;

  // Fixed field widths.
  localparam int ROW_W    = 32;
  localparam int SEG_IDX_W = 6;
  localparam int STAT_W   = 2;

  // Default number of segment slots.
  localparam int DEF_MAX_SEGMENTS = 64;

  // Command codes.
  localparam logic CMD_APPEND = 1'b0;
  localparam logic CMD_LOOKUP = 1'b1;

  // Status codes.
  localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
  localparam logic [STAT_W-1:0] STAT_OVERFLOW = 2'd1;
  localparam logic [STAT_W-1:0] STAT_PAST_END = 2'd2;
  localparam logic [STAT_W-1:0] STAT_FULL     = 2'd3;

  // Controller states.
  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } rsm_state_t;

  // Lookup beat handed from cell to cell.
  typedef struct packed {
    logic             valid;
    logic             hit;
    logic [ROW_W-1:0] row;
    logic [ROW_W-1:0] seg_start;
    logic [ROW_W-1:0] seg_end;
  } rsm_scan_t;

endpackage

/* sv/rsm_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsm_cell: one boundary cell
// Holds the end row of one segment. A lookup beat passing through the cell
// counts the segment if it ends at or before the row, or else marks the hit
// and takes this segment's end.
// ----------------------------------------------------------------------------
module rsm_cell #(
  parameter int CNT_W    = 7,
  parameter int CELL_IDX = 0
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_en,
  input  logic [CNT_W-1:0]  wr_idx,
  input  logic [31:0]       wr_data,
  input  rsm_pkg::rsm_scan_t scan_i,
  input  logic [CNT_W-1:0]  left_i,
  input  logic [CNT_W-1:0]  idx_i,
  output rsm_pkg::rsm_scan_t scan_o,
  output logic [CNT_W-1:0]  left_o,
  output logic [CNT_W-1:0]  idx_o
);
  import rsm_pkg::*;

  logic [ROW_W-1:0] end_r;
  rsm_scan_t        scan_r;
  rsm_scan_t        scan_nxt;
  logic [CNT_W-1:0] left_r;
  logic [CNT_W-1:0] left_nxt;
  logic [CNT_W-1:0] idx_r;
  logic [CNT_W-1:0] idx_nxt;
  logic             active;

  // The cell takes part only while the beat still has live segments left.
  assign active = scan_i.valid && (left_i != '0);

  // Compare this segment's end against the row carried by the beat.
  always_comb begin
    scan_nxt = scan_i;
    left_nxt = left_i;
    idx_nxt  = idx_i;
    if (active) begin
      left_nxt = left_i - CNT_W'(1);
      if (!scan_i.hit) begin
        if (end_r <= scan_i.row) begin
          idx_nxt            = idx_i + CNT_W'(1);
          scan_nxt.seg_start = end_r;
        end else begin
          scan_nxt.hit     = 1'b1;
          scan_nxt.seg_end = end_r;
        end
      end
    end
  end

  // Boundary storage, written by an accepted append.
  always_ff @(posedge clk) begin
    if (wr_en && (wr_idx == CNT_W'(CELL_IDX))) begin
      end_r <= wr_data;
    end
  end

  // Beat register. Only the valid bit is reset; the payload just follows.
  always_ff @(posedge clk) begin
    scan_r.hit       <= scan_nxt.hit;
    scan_r.row       <= scan_nxt.row;
    scan_r.seg_start <= scan_nxt.seg_start;
    scan_r.seg_end   <= scan_nxt.seg_end;
    left_r           <= left_nxt;
    idx_r            <= idx_nxt;
    if (!rst_n) begin
      scan_r.valid <= 1'b0;
    end else begin
      scan_r.valid <= scan_nxt.valid;
    end
  end

  assign scan_o = scan_r;
  assign left_o = left_r;
  assign idx_o  = idx_r;

endmodule

/* sv/rsm_chain.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsm_chain: row of boundary cells
// Cell k holds the end row of segment k. A lookup beat enters cell zero and
// moves one cell per clock to the far end of the row.
// ----------------------------------------------------------------------------
module rsm_chain #(
  parameter int MAX_SEGMENTS = 64,
  parameter int CNT_W        = 7
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               wr_en,
  input  logic [CNT_W-1:0]   wr_idx,
  input  logic [31:0]        wr_data,
  input  rsm_pkg::rsm_scan_t scan_i,
  input  logic [CNT_W-1:0]   left_i,
  output rsm_pkg::rsm_scan_t scan_o,
  output logic [CNT_W-1:0]   idx_o
);
  import rsm_pkg::*;

  rsm_scan_t        scan_w [MAX_SEGMENTS+1];
  logic [CNT_W-1:0] left_w [MAX_SEGMENTS+1];
  logic [CNT_W-1:0] idx_w  [MAX_SEGMENTS+1];

  // A fresh beat starts with no counted segments.
  assign scan_w[0] = scan_i;
  assign left_w[0] = left_i;
  assign idx_w[0]  = '0;

  for (genvar k = 0; k < MAX_SEGMENTS; k++) begin : g_cell
    rsm_cell #(
      .CNT_W    (CNT_W),
      .CELL_IDX (k)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .wr_en   (wr_en),
      .wr_idx  (wr_idx),
      .wr_data (wr_data),
      .scan_i  (scan_w[k]),
      .left_i  (left_w[k]),
      .idx_i   (idx_w[k]),
      .scan_o  (scan_w[k+1]),
      .left_o  (left_w[k+1]),
      .idx_o   (idx_w[k+1])
    );
  end

  assign scan_o = scan_w[MAX_SEGMENTS];
  assign idx_o  = idx_w[MAX_SEGMENTS];

  // A beat leaving the row has run out of live segments.
  a_left_spent : assert property (@(posedge clk) disable iff (!rst_n)
    scan_w[MAX_SEGMENTS].valid |-> (left_w[MAX_SEGMENTS] == '0))
    else $error("lookup beat left the chain with live segments unvisited");

endmodule

/* sv/row_segment_mapper.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// row_segment_mapper: global row to segment lookup
// Keeps the cumulative end rows of appended segments in a row of cells and
// maps a global row to its segment, start row and end row.
// ----------------------------------------------------------------------------
// Each accepted command gives exactly one result beat, shown for one cycle
// with out_valid; the receiver cannot stall it. An append, a refused append
// and a lookup of a row at or past the total do not enter the chain; the
// result appears the cycle after start, and busy stays low so a new command
// may be given every cycle. A lookup of a row inside the table sends a beat
// down the chain of MAX_SEGMENTS boundary cells, one cell per clock; busy is
// high until the beat leaves the last cell, and the result is registered
// from the beat as it leaves. No clearing pass follows reset.
// ----------------------------------------------------------------------------
module row_segment_mapper #(
  parameter int MAX_SEGMENTS = rsm_pkg::DEF_MAX_SEGMENTS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic                          in_command,
  input  logic [rsm_pkg::ROW_W-1:0]     in_segment_length,
  input  logic [rsm_pkg::ROW_W-1:0]     in_global_row,
  output logic                          out_valid,
  output logic [rsm_pkg::STAT_W-1:0]    out_status,
  output logic [rsm_pkg::SEG_IDX_W-1:0] out_segment_index,
  output logic [rsm_pkg::ROW_W-1:0]     out_segment_start,
  output logic [rsm_pkg::ROW_W-1:0]     out_segment_end,
  output logic [rsm_pkg::ROW_W-1:0]     out_total_rows
);
  import rsm_pkg::*;

  localparam int CNT_W = $clog2(MAX_SEGMENTS + 1);

  rsm_state_t        state_r;
  rsm_state_t        state_nxt;
  logic [CNT_W-1:0]  count_r;
  logic [ROW_W-1:0]  total_r;
  logic              out_valid_r;
  logic [STAT_W-1:0] out_status_r;
  logic [SEG_IDX_W-1:0] out_idx_r;
  logic [ROW_W-1:0]  out_start_r;
  logic [ROW_W-1:0]  out_end_r;
  logic [ROW_W-1:0]  out_total_r;

  logic              accept;
  logic [ROW_W:0]    sum;
  logic              overflow;
  logic              full;
  logic              append_ok;
  logic              launch;
  rsm_scan_t         scan_in;
  rsm_scan_t         scan_out;
  logic [CNT_W-1:0]  chain_idx;

  logic [STAT_W-1:0]    res_status;
  logic [SEG_IDX_W-1:0] res_idx;
  logic [ROW_W-1:0]     res_start;
  logic [ROW_W-1:0]     res_end;
  logic [ROW_W-1:0]     res_total;

  assign accept    = start && !busy;
  assign sum       = {1'b0, total_r} + {1'b0, in_segment_length};
  assign overflow  = sum[ROW_W];
  assign full      = (count_r == CNT_W'(MAX_SEGMENTS));
  assign append_ok = accept && (in_command == CMD_APPEND) && !overflow && !full;
  assign launch    = accept && (in_command == CMD_LOOKUP) && (in_global_row < total_r);

  // Lookup beat entering the first cell.
  always_comb begin
    scan_in.valid     = launch;
    scan_in.hit       = 1'b0;
    scan_in.row       = in_global_row;
    scan_in.seg_start = '0;
    scan_in.seg_end   = '0;
  end

  rsm_chain #(
    .MAX_SEGMENTS (MAX_SEGMENTS),
    .CNT_W        (CNT_W)
  ) u_chain (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (append_ok),
    .wr_idx  (count_r),
    .wr_data (sum[ROW_W-1:0]),
    .scan_i  (scan_in),
    .left_i  (count_r),
    .scan_o  (scan_out),
    .idx_o   (chain_idx)
  );

  // Results that finish in the cycle of acceptance.
  always_comb begin
    res_status = STAT_OK;
    res_idx    = '0;
    res_start  = '0;
    res_end    = '0;
    res_total  = total_r;
    if (in_command == CMD_APPEND) begin
      if (overflow) begin
        res_status = STAT_OVERFLOW;
      end else if (full) begin
        res_status = STAT_FULL;
      end else begin
        res_idx   = SEG_IDX_W'(count_r);
        res_start = total_r;
        res_end   = sum[ROW_W-1:0];
        res_total = sum[ROW_W-1:0];
      end
    end else begin
      res_status = STAT_PAST_END;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (launch) state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (scan_out.valid) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Controller outputs.
  always_comb begin
    busy = 1'b0;
    unique case (state_r)
      ST_IDLE: busy = 1'b0;
      ST_SCAN: busy = 1'b1;
      default: busy = 1'b0;
    endcase
  end

  // Control state, segment count and total.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= (accept && !launch) || scan_out.valid;
      if (append_ok) begin
        count_r <= count_r + CNT_W'(1);
        total_r <= sum[ROW_W-1:0];
      end
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (accept && !launch) begin
      out_status_r <= res_status;
      out_idx_r    <= res_idx;
      out_start_r  <= res_start;
      out_end_r    <= res_end;
      out_total_r  <= res_total;
    end else if (scan_out.valid) begin
      out_status_r <= STAT_OK;
      out_idx_r    <= SEG_IDX_W'(chain_idx);
      out_start_r  <= scan_out.seg_start;
      out_end_r    <= scan_out.seg_end;
      out_total_r  <= total_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_segment_index = out_idx_r;
  assign out_segment_start = out_start_r;
  assign out_segment_end   = out_end_r;
  assign out_total_rows    = out_total_r;

  // A lookup beat only leaves the chain while the controller waits for it.
  a_scan_in_state : assert property (@(posedge clk) disable iff (!rst_n)
    scan_out.valid |-> (state_r == ST_SCAN))
    else $error("lookup beat left the chain outside a scan");

  // Every command that does not enter the chain answers in the next cycle.
  a_quick_result : assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !launch) |=> out_valid_r)
    else $error("one-cycle command gave no result");

  // A beat that leaves the chain always found its segment.
  a_scan_hit : assert property (@(posedge clk) disable iff (!rst_n)
    scan_out.valid |-> scan_out.hit)
    else $error("lookup beat found no segment end above the row");

  // The segment count never passes the table bound.
  a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_SEGMENTS))
    else $error("segment count beyond table bound");

  // The total row count never shrinks outside reset.
  a_total_grows : assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (total_r >= $past(total_r)))
    else $error("total row count decreased");

endmodule
